/* sv/shs_pkg.sv */
// Shared constants, request codes and the bin store command type for the
// score histogram statistics core. Depends on nothing.
`default_nettype none

package shs_pkg;

  // Default configuration of the core.
  localparam int SHS_MAX_SCORE  = 30;
  localparam int SHS_COUNT_BITS = 16;

  // Width of the running score sum, which saturates at its all-ones value.
  localparam int SHS_SUM_BITS = 24;

  // Request codes; the unused code behaves as a query.
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Command bundle from the sequencer to the bin store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } shs_mem_cmd_t;

endpackage

`default_nettype wire

/* sv/score_histogram_statistics_core.sv */
// Channel   | ports                                   | handshake
// ----------+-----------------------------------------+--------------------------------
// request   | in_opcode, in_score                     | taken when start && !busy
// result    | out_entry_count .. out_rejected         | out_valid, one cycle, no stall
//
// A request whose score lands in a bin has its bin read at the accepting
// edge; the bin is then written back, the divider is loaded, the bit-serial
// division of the sum by the present count runs and the result is
// registered. Other requests skip the bin read and the write-back.
// The next request may be accepted in the cycle the result shows.
// Reset is synchronous and active low; it empties all statistics at once.
// The result strobe lasts exactly one cycle and cannot be held off.
//
// Top level of the score histogram statistics core. Uses shs_pkg,
// shs_bin_store and shs_divider.
`default_nettype none

module score_histogram_statistics_core import shs_pkg::*; #(
  parameter int MAX_SCORE  = SHS_MAX_SCORE,
  parameter int COUNT_BITS = SHS_COUNT_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_opcode,
  input  wire logic signed [8:0] in_score,
  output logic                   out_valid,
  output logic [15:0]            out_entry_count,
  output logic [15:0]            out_absent_count,
  output logic [7:0]             out_highest_score,
  output logic [7:0]             out_lowest_score,
  output logic [7:0]             out_mean_score,
  output logic [15:0]            out_mode_count,
  output logic [7:0]             out_mode_score,
  output logic                   out_none_present,
  output logic                   out_rejected
);

  localparam int DEPTH = MAX_SCORE + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [SHS_SUM_BITS-1:0] SUM_MAX   = {SHS_SUM_BITS{1'b1}};
  localparam logic [7:0]              MAX_S     = 8'(MAX_SCORE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVGO,
    ST_DIVWAIT
  } state_t;

  state_t state_r, state_nxt;

  // Running statistics.
  logic [COUNT_BITS-1:0]   entries_r, entries_nxt;
  logic [COUNT_BITS-1:0]   absent_r,  absent_nxt;
  logic [SHS_SUM_BITS-1:0] sum_r,     sum_nxt;
  logic [7:0]              high_r,    high_nxt;
  logic [7:0]              low_r,     low_nxt;
  logic [COUNT_BITS-1:0]   best_cnt_r, best_cnt_nxt;
  logic [7:0]              best_sc_r,  best_sc_nxt;

  // Request held while it is worked on.
  logic [7:0] score_r, score_nxt;
  logic       rej_r,   rej_nxt;

  // Registered result.
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] o_entry_r, o_absent_r, o_mcount_r;
  logic [7:0]  o_high_r, o_low_r, o_mean_r, o_mscore_r;
  logic        o_none_r, o_rej_r;

  // Memory and divider hookup.
  shs_mem_cmd_t            mem_cmd;
  logic [COUNT_BITS-1:0]   rd_count;
  logic [COUNT_BITS-1:0]   new_cnt;
  logic [COUNT_BITS-1:0]   present;
  logic                    div_go;
  logic                    div_done;
  logic [SHS_SUM_BITS-1:0] div_quo;
  logic [SHS_SUM_BITS:0]   sum_ext;
  logic                    accept;

  assign accept  = start && (state_r == ST_IDLE);
  assign present = entries_r - absent_r;
  assign new_cnt = rd_count + 1'b1;
  assign sum_ext = {1'b0, sum_r} + (SHS_SUM_BITS + 1)'(score_r);

  shs_bin_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (COUNT_BITS)
  ) u_bins (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (mem_cmd),
    .rd_addr  (in_score[AW-1:0]),
    .wr_addr  (score_r[AW-1:0]),
    .wr_data  (new_cnt),
    .rd_count (rd_count)
  );

  shs_divider #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (sum_r),
    .divisor  (present),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer: decode the request, update the bin, then divide.
  always_comb begin
    state_nxt     = state_r;
    entries_nxt   = entries_r;
    absent_nxt    = absent_r;
    sum_nxt       = sum_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    best_cnt_nxt  = best_cnt_r;
    best_sc_nxt   = best_sc_r;
    score_nxt     = score_r;
    rej_nxt       = rej_r;
    out_valid_nxt = 1'b0;
    mem_cmd       = '0;
    div_go        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          score_nxt = in_score[7:0];
          rej_nxt   = 1'b0;
          state_nxt = ST_DIVGO;
          case (in_opcode)
            OP_RECORD: begin
              if (entries_r != COUNT_MAX) begin
                if (in_score[8]) begin
                  absent_nxt  = absent_r + 1'b1;
                  entries_nxt = entries_r + 1'b1;
                end else if (in_score[7:0] > MAX_S) begin
                  rej_nxt = 1'b1;
                end else begin
                  mem_cmd.rd_en = 1'b1;
                  state_nxt     = ST_UPDATE;
                end
              end
            end
            OP_CLEAR: begin
              mem_cmd.clr  = 1'b1;
              entries_nxt  = '0;
              absent_nxt   = '0;
              sum_nxt      = '0;
              high_nxt     = '0;
              low_nxt      = MAX_S;
              best_cnt_nxt = '0;
              best_sc_nxt  = '0;
            end
            default: begin
              // Query and the unused code change nothing.
            end
          endcase
        end
      end

      ST_UPDATE: begin
        // Bin count is back from memory: write it back and fold it in.
        mem_cmd.wr_en = 1'b1;
        if ((new_cnt > best_cnt_r) ||
            ((new_cnt == best_cnt_r) && (score_r < best_sc_r))) begin
          best_cnt_nxt = new_cnt;
          best_sc_nxt  = score_r;
        end
        if (score_r > high_r) begin
          high_nxt = score_r;
        end
        if (score_r < low_r) begin
          low_nxt = score_r;
        end
        sum_nxt     = sum_ext[SHS_SUM_BITS] ? SUM_MAX : sum_ext[SHS_SUM_BITS-1:0];
        entries_nxt = entries_r + 1'b1;
        state_nxt   = ST_DIVGO;
      end

      ST_DIVGO: begin
        div_go    = 1'b1;
        state_nxt = ST_DIVWAIT;
      end

      ST_DIVWAIT: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_valid_nxt) begin
      o_entry_r  <= 16'(entries_r);
      o_absent_r <= 16'(absent_r);
      o_high_r   <= high_r;
      o_low_r    <= low_r;
      o_mean_r   <= (present == '0) ? 8'd0 : div_quo[7:0];
      o_mcount_r <= 16'(best_cnt_r);
      o_mscore_r <= best_sc_r;
      o_none_r   <= (present == '0);
      o_rej_r    <= rej_r;
    end
  end

  // Statistics registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r  <= '0;
      absent_r   <= '0;
      sum_r      <= '0;
      high_r     <= '0;
      low_r      <= MAX_S;
      best_cnt_r <= '0;
      best_sc_r  <= '0;
    end else begin
      entries_r  <= entries_nxt;
      absent_r   <= absent_nxt;
      sum_r      <= sum_nxt;
      high_r     <= high_nxt;
      low_r      <= low_nxt;
      best_cnt_r <= best_cnt_nxt;
      best_sc_r  <= best_sc_nxt;
    end
    score_r <= score_nxt;
    rej_r   <= rej_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_entry_count   = o_entry_r;
  assign out_absent_count  = o_absent_r;
  assign out_highest_score = o_high_r;
  assign out_lowest_score  = o_low_r;
  assign out_mean_score    = o_mean_r;
  assign out_mode_count    = o_mcount_r;
  assign out_mode_score    = o_mscore_r;
  assign out_none_present  = o_none_r;
  assign out_rejected      = o_rej_r;

endmodule

`default_nettype wire

/* sv/shs_bin_store.sv */
// Histogram bin memory with one synchronous read port and one write port.
// Per-entry valid bits make an unwritten or cleared bin read as zero. Uses shs_pkg.
`default_nettype none

module shs_bin_store import shs_pkg::*; #(
  parameter int DEPTH = SHS_MAX_SCORE + 1,
  parameter int AW    = $clog2(SHS_MAX_SCORE + 1),
  parameter int DW    = SHS_COUNT_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire shs_mem_cmd_t  cmd,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  output logic      [DW-1:0] rd_count
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [DW-1:0]    rd_data_r;
  logic             rd_vld_r;

  // Memory array: registered read, plain write.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
    end
  end

  // Valid bits are dropped at once by reset or a clear request.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // A bin that was never written since the last clear counts zero.
  assign rd_count = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

/* sv/shs_divider.sv */
// Restoring bit-serial divider: one quotient bit per cycle for the mean.
// Uses shs_pkg for the sum width.
`default_nettype none

module shs_divider import shs_pkg::*; #(
  parameter int COUNT_BITS = SHS_COUNT_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    go,
  input  wire logic [SHS_SUM_BITS-1:0] dividend,
  input  wire logic [COUNT_BITS-1:0]   divisor,
  output logic                         done,
  output logic [SHS_SUM_BITS-1:0]      quotient
);

  localparam int CW = $clog2(SHS_SUM_BITS);

  logic [COUNT_BITS-1:0]   rem_r,  rem_nxt;
  logic [SHS_SUM_BITS-1:0] quo_r,  quo_nxt;
  logic [COUNT_BITS-1:0]   dvs_r;
  logic [CW-1:0]           cnt_r,  cnt_nxt;
  logic                    run_r,  run_nxt;
  logic                    done_r, done_nxt;
  logic [COUNT_BITS:0]     trial;
  logic [COUNT_BITS:0]     diff;
  logic                    fits;

  // One trial subtraction per step.
  always_comb begin
    trial = {rem_r, quo_r[SHS_SUM_BITS-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  // Step control.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CW'(SHS_SUM_BITS - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_nxt = {quo_r[SHS_SUM_BITS-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (go) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* sv/shs_checker.sv */
// Port-level checks for score_histogram_statistics_core, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module shs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [7:0]  out_highest_score,
  input wire logic [7:0]  out_lowest_score,
  input wire logic [7:0]  out_mean_score,
  input wire logic        out_none_present
);

  // An accepted request makes the core busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("core not busy after accepting a request");

  // A result shows only once its request has finished.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  // The strobe never lasts longer than one cycle.
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // With no present scores, the mean and the highest score read zero.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_none_present) |->
      (out_mean_score == 8'd0 && out_highest_score == 8'd0))
    else $error("empty statistics with nonzero mean or highest score");

  // Present scores keep the lowest, mean and highest in order.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_none_present) |->
      (out_lowest_score <= out_mean_score && out_mean_score <= out_highest_score))
    else $error("lowest, mean and highest scores out of order");

endmodule

bind score_histogram_statistics_core shs_checker u_shs_checker (.*);

`default_nettype wire
